[design/rau_pkg.sv]
// Package for the rational arithmetic unit: types, codes, widths and helpers.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int FIELD_W   = 32;
    localparam int PROD_W    = 64;
    localparam int WIDTH_DEF = 32;
    localparam int CMD_W     = 3;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int SH_W      = $clog2(PROD_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_COMBINE,
        S_GCD_GO,
        S_GCD_WAIT,
        S_DIV_NUM_GO,
        S_DIV_NUM_WAIT,
        S_DIV_DEN_GO,
        S_DIV_DEN_WAIT,
        S_CHECK,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        G_IDLE,
        G_EVEN,
        G_AODD,
        G_LOOP,
        G_SHL
    } t_gcd_state;

    // Magnitude of a two's complement field; the most negative value maps to 2^31.
    function automatic logic [FIELD_W-1:0] mag_of(input logic [FIELD_W-1:0] w);
        mag_of = w[FIELD_W-1] ? (~w + FIELD_W'(1)) : w;
    endfunction

endpackage
`default_nettype wire

[design/rau_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rau_div
    import rau_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [PROD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_quot
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_q, n_q;
    logic [PROD_W-1:0] r_d, n_d;
    logic [PROD_W:0]   rem_sh;
    logic [PROD_W:0]   diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_sh = {r_rem, r_q[PROD_W-1]};
        diff   = rem_sh - {1'b0, r_d};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(PROD_W - 1);
            n_rem  = '0;
            n_q    = i_dividend;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_d}) begin
                n_rem = diff[PROD_W-1:0];
                n_q   = {r_q[PROD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[PROD_W-1:0];
                n_q   = {r_q[PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

[design/rau_gcd.sv]
// Binary gcd unit, one shift or subtract step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd
    import rau_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_a,
    input  wire logic [PROD_W-1:0] i_b,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_g
);

    t_gcd_state        r_state, n_state;
    logic              r_done, n_done;
    logic [PROD_W-1:0] r_a, n_a;
    logic [PROD_W-1:0] r_b, n_b;
    logic [SH_W-1:0]   r_sh, n_sh;
    logic [PROD_W-1:0] r_g, n_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a  <= n_a;
        r_b  <= n_b;
        r_sh <= n_sh;
        r_g  <= n_g;
    end

    // Strip common twos, make a odd, then halve or subtract until b drops to zero and restore the twos
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_a     = r_a;
        n_b     = r_b;
        n_sh    = r_sh;
        n_g     = r_g;
        case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_a  = i_a;
                    n_b  = i_b;
                    n_sh = '0;
                    if (i_a == '0) begin
                        n_g    = i_b;
                        n_done = 1'b1;
                    end else begin
                        n_state = G_EVEN;
                    end
                end
            end
            G_EVEN: begin
                if (!r_a[0] && !r_b[0]) begin
                    n_a  = r_a >> 1;
                    n_b  = r_b >> 1;
                    n_sh = r_sh + SH_W'(1);
                end else begin
                    n_state = G_AODD;
                end
            end
            G_AODD: begin
                if (!r_a[0]) n_a = r_a >> 1;
                else n_state = G_LOOP;
            end
            G_LOOP: begin
                if (r_b == '0) begin
                    n_state = G_SHL;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a > r_b) begin
                    n_a = r_b;
                    n_b = r_a - r_b;
                end else begin
                    n_b = r_b - r_a;
                end
            end
            G_SHL: begin
                n_g     = r_a << r_sh;
                n_done  = 1'b1;
                n_state = G_IDLE;
            end
            default: n_state = G_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule
`default_nettype wire

[design/rational_arith_unit.sv]
// Top level: fraction arithmetic with one shared multiplier, gcd unit and divider.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | i_cmd, i_a_num, i_a_den, i_b_num, i_b_den
//  output  | out       | o_out_valid / i_out_ready | o_res_num, o_res_den, o_cmp_result, o_status
//
// One item at a time: the products on the shared multiplier, a combine step, the binary gcd
// and two divisions, of the numerator and then of the denominator, by the gcd.
// Compare, zero-denominator and unused codes skip the gcd and the divisions.
// The gcd loop and the single 64-bit divider set the item time.
// Reset (synchronous, active low) returns the sequencer to idle.
// A result waits in the output registers until taken; no new item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [FIELD_W-1:0] i_a_num,
    input  wire logic [FIELD_W-1:0] i_a_den,
    input  wire logic [FIELD_W-1:0] i_b_num,
    input  wire logic [FIELD_W-1:0] i_b_den,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [FIELD_W-1:0]      o_res_num,
    output logic [FIELD_W-1:0]      o_res_den,
    output logic [1:0]              o_cmp_result,
    output logic [1:0]              o_status
);

    localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (WIDTH - 1);

    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [FIELD_W-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic               r_an_s, n_an_s, r_ad_s, n_ad_s, r_bn_s, n_bn_s, r_bd_s, n_bd_s;
    logic [PROD_W-1:0]  r_pa, n_pa, r_pb, n_pb, r_pc, n_pc;
    logic               r_pa_s, n_pa_s, r_pb_s, n_pb_s, r_pc_s, n_pc_s;
    logic [PROD_W-1:0]  r_num, n_num, r_den, n_den;
    logic               r_num_s, n_num_s, r_den_s, n_den_s;
    logic [FIELD_W-1:0] r_res_num, n_res_num, r_res_den, n_res_den;
    logic [1:0]         r_cmp, n_cmp, r_status, n_status;

    logic [FIELD_W-1:0] mul_x, mul_y;
    logic               mul_xs, mul_ys;
    logic [PROD_W-1:0]  mul_p;
    logic               mul_s;
    logic               add_like;
    logic               b_s;
    logic [PROD_W-1:0]  sum;
    logic               sum_s;
    logic               fit_num, fit_den;

    logic               gcd_start, gcd_done;
    logic [PROD_W-1:0]  gcd_g;
    logic               div_start, div_done;
    logic [PROD_W-1:0]  div_n, div_q;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_a     (r_num),
        .i_b     (r_den),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (gcd_g),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign gcd_start = (r_state == S_GCD_GO);
    assign div_start = (r_state == S_DIV_NUM_GO) || (r_state == S_DIV_DEN_GO);
    assign div_n     = (r_state == S_DIV_NUM_GO) ? r_num : r_den;
    assign add_like  = (r_cmd == CMD_ADD) || (r_cmd == CMD_SUB) || (r_cmd == CMD_CMP);

    // Select multiplier operands for the current product step
    always_comb begin
        mul_x  = r_ad;
        mul_xs = r_ad_s;
        mul_y  = r_bd;
        mul_ys = r_bd_s;
        case (r_state)
            S_MUL_A: begin
                mul_x  = r_an;
                mul_xs = r_an_s;
                mul_y  = (r_cmd == CMD_MUL) ? r_bn : r_bd;
                mul_ys = (r_cmd == CMD_MUL) ? r_bn_s : r_bd_s;
            end
            S_MUL_B: begin
                mul_y  = (r_cmd == CMD_MUL) ? r_bd : r_bn;
                mul_ys = (r_cmd == CMD_MUL) ? r_bd_s : r_bn_s;
            end
            default: ;
        endcase
        mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);
        mul_s = (mul_p != '0) && (mul_xs != mul_ys);
    end

    // Signed-magnitude sum (or difference) of the two cross products, and the output range checks
    always_comb begin
        b_s = (r_cmd == CMD_ADD) ? r_pb_s : ((r_pb != '0) && !r_pb_s);
        if (r_pa_s == b_s) begin
            sum   = r_pa + r_pb;
            sum_s = r_pa_s;
        end else if (r_pa >= r_pb) begin
            sum   = r_pa - r_pb;
            sum_s = r_pa_s;
        end else begin
            sum   = r_pb - r_pa;
            sum_s = b_s;
        end
        if (sum == '0) sum_s = 1'b0;
        fit_num = r_num_s ? (r_num <= LIM) : (r_num < LIM);
        fit_den = r_den_s ? (r_den <= LIM) : (r_den < LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        r_cmd     <= n_cmd;
        r_an      <= n_an;   r_ad   <= n_ad;   r_bn   <= n_bn;   r_bd   <= n_bd;
        r_an_s    <= n_an_s; r_ad_s <= n_ad_s; r_bn_s <= n_bn_s; r_bd_s <= n_bd_s;
        r_pa      <= n_pa;   r_pb   <= n_pb;   r_pc   <= n_pc;
        r_pa_s    <= n_pa_s; r_pb_s <= n_pb_s; r_pc_s <= n_pc_s;
        r_num     <= n_num;  r_den  <= n_den;
        r_num_s   <= n_num_s;
        r_den_s   <= n_den_s;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_cmp     <= n_cmp;
        r_status  <= n_status;
    end

    // Sequencer: next state and register updates
    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd;
        n_an_s = r_an_s; n_ad_s = r_ad_s; n_bn_s = r_bn_s; n_bd_s = r_bd_s;
        n_pa = r_pa; n_pb = r_pb; n_pc = r_pc;
        n_pa_s = r_pa_s; n_pb_s = r_pb_s; n_pc_s = r_pc_s;
        n_num = r_num; n_den = r_den; n_num_s = r_num_s; n_den_s = r_den_s;
        n_res_num = r_res_num; n_res_den = r_res_den;
        n_cmp = r_cmp; n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_cmd;
                    n_an      = mag_of(i_a_num); n_an_s = i_a_num[FIELD_W-1];
                    n_ad      = mag_of(i_a_den); n_ad_s = i_a_den[FIELD_W-1];
                    n_bn      = mag_of(i_b_num); n_bn_s = i_b_num[FIELD_W-1];
                    n_bd      = mag_of(i_b_den); n_bd_s = i_b_den[FIELD_W-1];
                    n_res_num = '0;
                    n_res_den = '0;
                    n_cmp     = CMP_LESS;
                    n_status  = ST_OK;
                    if (i_cmd > CMD_CMP) n_state = S_OUT;
                    else n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                n_pa    = mul_p;
                n_pa_s  = mul_s;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_pb   = mul_p;
                n_pb_s = mul_s;
                if ((r_cmd == CMD_ADD) || (r_cmd == CMD_SUB)) n_state = S_MUL_C;
                else n_state = S_COMBINE;
            end
            S_MUL_C: begin
                n_pc    = mul_p;
                n_pc_s  = mul_s;
                n_state = S_COMBINE;
            end
            S_COMBINE: begin
                n_num   = add_like ? sum : r_pa;
                n_num_s = add_like ? sum_s : r_pa_s;
                n_den   = add_like ? r_pc : r_pb;
                n_den_s = add_like ? r_pc_s : r_pb_s;
                if (r_cmd == CMD_CMP) begin
                    if (sum == '0) n_cmp = CMP_EQUAL;
                    else if (sum_s) n_cmp = CMP_LESS;
                    else n_cmp = CMP_GREATER;
                    n_state = S_OUT;
                end else if (n_den == '0) begin
                    n_status = ST_ZERO_DEN;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_GCD_GO;
                end
            end
            S_GCD_GO:   n_state = S_GCD_WAIT;
            S_GCD_WAIT: if (gcd_done) n_state = S_DIV_NUM_GO;
            S_DIV_NUM_GO: n_state = S_DIV_NUM_WAIT;
            S_DIV_NUM_WAIT: begin
                if (div_done) begin
                    n_num   = div_q;
                    n_state = S_DIV_DEN_GO;
                end
            end
            S_DIV_DEN_GO: n_state = S_DIV_DEN_WAIT;
            S_DIV_DEN_WAIT: begin
                if (div_done) begin
                    n_den   = div_q;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!fit_num || !fit_den) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_res_num = r_num_s ? (~r_num[FIELD_W-1:0] + FIELD_W'(1))
                                        : r_num[FIELD_W-1:0];
                    n_res_den = r_den_s ? (~r_den[FIELD_W-1:0] + FIELD_W'(1))
                                        : r_den[FIELD_W-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_cmp_result = r_cmp;
    assign o_status     = r_status;

endmodule
`default_nettype wire

[design/rau_checker.sv]
// Port-level checks for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker
    import rau_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [FIELD_W-1:0] o_res_num,
    input wire logic [FIELD_W-1:0] o_res_den,
    input wire logic [1:0]         o_cmp_result,
    input wire logic [1:0]         o_status
);

    // Never take an item while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // Drop ready right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after accept");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_res_num) && $stable(o_res_den) && $stable(o_status)))
        else $error("stalled result changed");

    // Error results carry zero fraction and a less-than compare code
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            ((o_res_num == '0) && (o_res_den == '0) && (o_cmp_result == CMP_LESS)))
        else $error("error result not cleared");

    // Compare answers other than less carry no fraction and no error
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_cmp_result != CMP_LESS)) |->
            ((o_res_num == '0) && (o_res_den == '0) && (o_status == ST_OK)))
        else $error("compare result mixed with fraction");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
`default_nettype wire
